// ----- design/keypad_command_framer_defines.svh -----
// ----------------------------------------------------------------------------
// Keypad command framer assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_COMMAND_FRAMER_DEFINES_SVH
`define KEYPAD_COMMAND_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define KCF_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define KCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KCF_ASSERT(lbl, expr, msg)
`define KCF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- design/kcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad command framer package
// Character codes, controller/datapath interface types and digit helpers.
// ----------------------------------------------------------------------------
package kcf_pkg;

  localparam int unsigned KeyW = 7;

  // ASCII codes used by the framer
  localparam logic [KeyW-1:0] CH_NUL    = 7'h00;
  localparam logic [KeyW-1:0] CH_LF     = 7'h0A;
  localparam logic [KeyW-1:0] CH_CR     = 7'h0D;
  localparam logic [KeyW-1:0] CH_HASH   = 7'h23;
  localparam logic [KeyW-1:0] CH_STAR   = 7'h2A;
  localparam logic [KeyW-1:0] CH_PLUS   = 7'h2B;
  localparam logic [KeyW-1:0] CH_MINUS  = 7'h2D;
  localparam logic [KeyW-1:0] CH_0      = 7'h30;
  localparam logic [KeyW-1:0] CH_1      = 7'h31;
  localparam logic [KeyW-1:0] CH_2      = 7'h32;
  localparam logic [KeyW-1:0] CH_3      = 7'h33;
  localparam logic [KeyW-1:0] CH_4      = 7'h34;
  localparam logic [KeyW-1:0] CH_5      = 7'h35;
  localparam logic [KeyW-1:0] CH_6      = 7'h36;
  localparam logic [KeyW-1:0] CH_7      = 7'h37;
  localparam logic [KeyW-1:0] CH_8      = 7'h38;
  localparam logic [KeyW-1:0] CH_9      = 7'h39;
  localparam logic [KeyW-1:0] CH_A      = 7'h41;
  localparam logic [KeyW-1:0] CH_B      = 7'h42;
  localparam logic [KeyW-1:0] CH_C      = 7'h43;
  localparam logic [KeyW-1:0] CH_D      = 7'h44;
  localparam logic [KeyW-1:0] CH_E      = 7'h45;
  localparam logic [KeyW-1:0] CH_G      = 7'h47;
  localparam logic [KeyW-1:0] CH_P      = 7'h50;
  localparam logic [KeyW-1:0] CH_R      = 7'h52;
  localparam logic [KeyW-1:0] CH_S      = 7'h53;
  localparam logic [KeyW-1:0] CH_U      = 7'h55;
  localparam logic [KeyW-1:0] CH_X      = 7'h58;
  localparam logic [KeyW-1:0] CH_Y      = 7'h59;
  localparam logic [KeyW-1:0] CH_LBRACK = 7'h5B;
  localparam logic [KeyW-1:0] CH_RBRACK = 7'h5D;
  localparam logic [KeyW-1:0] CH_LOW_A  = 7'h61;

  localparam logic [KeyW-1:0] DIST_MAX      = 7'd99;
  localparam logic [KeyW-1:0] LIMIT_RESET   = 7'd99;
  localparam logic [7:0]      CSUM_MODULUS  = 8'hA5;

  // Frame buffer: '[' + body + '#', at most seven bytes
  localparam int unsigned FrameDepth = 7;
  localparam int unsigned FrameIdxW  = $clog2(FrameDepth);

  // Controller state, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } kcf_state_e;

  // Controller to datapath
  typedef struct packed {
    logic store_key;   // stash a non-terminator key
    logic load_frame;  // build frame from store, clear store
    logic advance;     // current frame byte taken
  } kcf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic key_null;    // no key pressed
    logic key_hash;    // terminator key
    logic last_byte;   // current byte is the line feed
  } kcf_sts_t;

  // Tens digit of a value below 128, by reciprocal multiply
  function automatic logic [3:0] dec_tens(input logic [KeyW-1:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  // Ones digit of a value below 128
  function automatic logic [3:0] dec_ones(input logic [KeyW-1:0] v);
    logic [KeyW-1:0] tens10;
    tens10 = 7'(dec_tens(v)) * 7'd10;
    return 4'(v - tens10);
  endfunction

  // Decimal digit to ASCII
  function automatic logic [KeyW-1:0] dec_char(input logic [3:0] d);
    return CH_0 + 7'(d);
  endfunction

  // Nibble to lowercase hex ASCII
  function automatic logic [KeyW-1:0] hex_char(input logic [3:0] d);
    logic [KeyW-1:0] c;
    if (d < 4'd10) begin
      c = CH_0 + 7'(d);
    end else begin
      c = CH_LOW_A + 7'(d) - 7'd10;
    end
    return c;
  endfunction

endpackage

// ----- design/kcf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad command framer datapath
// Key store, distance limit register, frame buffer, byte index and checksum.
// ----------------------------------------------------------------------------
`include "keypad_command_framer_defines.svh"

module kcf_datapath import kcf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [KeyW-1:0] key_char_i,
  input  logic            cfg_we_i,
  input  logic [KeyW-1:0] cfg_data_i,
  input  kcf_cmd_t        cmd_i,
  output kcf_sts_t        sts_o,
  output logic [7:0]      frame_byte_o
);

  // Positions after the buffered part of the frame
  localparam logic [3:0] TAIL_HEX_HI = 4'd0;
  localparam logic [3:0] TAIL_HEX_LO = 4'd1;
  localparam logic [3:0] TAIL_RBRACK = 4'd2;
  localparam logic [3:0] TAIL_CR     = 4'd3;
  localparam logic [3:0] TAIL_LAST   = 4'd4;

  logic [KeyW-1:0] limit_q;
  logic [1:0]      key_count_q, key_count_d;
  logic [KeyW-1:0] first_q, first_d;
  logic [KeyW-1:0] second_q, second_d;
  logic [KeyW-1:0] third_q, third_d;
  logic [KeyW-1:0] dist_q, dist_d;
  logic            ended_q, ended_d;

  logic [KeyW-1:0] frame_q [FrameDepth];
  logic [KeyW-1:0] frame_d [FrameDepth];
  logic [2:0]      nb_q, nb_d;
  logic [3:0]      idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;

  logic            key_is_digit;
  logic [9:0]      dist_acc;
  logic [KeyW-1:0] dist_cap;
  logic            slot_neg;
  logic [KeyW-1:0] slot_mag;
  logic [KeyW-1:0] slot_c0, slot_c1, slot_c2;
  logic            slot_len3;
  logic [KeyW-1:0] cmd_letter;
  logic            cmd_has_slot;
  logic            in_body;
  logic [3:0]      tail_pos;
  logic [KeyW-1:0] cur_byte;
  logic [8:0]      sum_add;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Key store update
  assign key_is_digit = key_char_i inside {[CH_0:CH_9]};
  assign dist_acc     = 10'(dist_q) * 10'd10 + 10'(key_char_i - CH_0);

  always_comb begin
    key_count_d = key_count_q;
    first_d     = first_q;
    second_d    = second_q;
    third_d     = third_q;
    dist_d      = dist_q;
    ended_d     = ended_q;
    if (cmd_i.load_frame) begin
      key_count_d = '0;
      first_d     = '0;
      second_d    = '0;
      third_d     = '0;
      dist_d      = '0;
      ended_d     = 1'b0;
    end else if (cmd_i.store_key) begin
      case (key_count_q)
        2'd0: begin
          first_d = key_char_i;
        end
        2'd1: begin
          second_d = key_char_i;
        end
        default: begin
          if (key_count_q == 2'd2) begin
            third_d = key_char_i;
          end
          if (!ended_q && key_is_digit) begin
            dist_d = (dist_acc > 10'(DIST_MAX)) ? DIST_MAX : dist_acc[KeyW-1:0];
          end else begin
            ended_d = 1'b1;
          end
        end
      endcase
      if (key_count_q != 2'd3) begin
        key_count_d = key_count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      first_q     <= '0;
      second_q    <= '0;
      third_q     <= '0;
      dist_q      <= '0;
      ended_q     <= 1'b0;
    end else begin
      key_count_q <= key_count_d;
      first_q     <= first_d;
      second_q    <= second_d;
      third_q     <= third_d;
      dist_q      <= dist_d;
      ended_q     <= ended_d;
    end
  end

  // Slot text, like %02d of (third key - '0')
  assign slot_neg = third_q < CH_0;
  assign slot_mag = slot_neg ? (CH_0 - third_q) : (third_q - CH_0);

  always_comb begin
    slot_c2   = CH_HASH;
    slot_len3 = 1'b0;
    if (slot_neg) begin
      slot_c0 = CH_MINUS;
      if (slot_mag >= 7'd10) begin
        slot_c1   = dec_char(dec_tens(slot_mag));
        slot_c2   = dec_char(dec_ones(slot_mag));
        slot_len3 = 1'b1;
      end else begin
        slot_c1 = dec_char(dec_ones(slot_mag));
      end
    end else begin
      slot_c0 = dec_char(dec_tens(slot_mag));
      slot_c1 = dec_char(dec_ones(slot_mag));
    end
  end

  // Slot/actuator command letter
  always_comb begin
    cmd_has_slot = 1'b0;
    case (second_q)
      CH_1: begin
        cmd_letter   = CH_S;
        cmd_has_slot = 1'b1;
      end
      CH_2: begin
        cmd_letter   = CH_G;
        cmd_has_slot = 1'b1;
      end
      CH_3: cmd_letter = CH_D;
      CH_4: cmd_letter = CH_U;
      CH_5: cmd_letter = CH_P;
      CH_6: begin
        cmd_letter   = CH_E;
        cmd_has_slot = 1'b1;
      end
      CH_7: cmd_letter = CH_A;
      default: begin
        cmd_letter   = CH_R;
        cmd_has_slot = 1'b1;
      end
    endcase
  end

  // Frame assembly from the store
  assign dist_cap = (dist_q > limit_q) ? limit_q : dist_q;

  always_comb begin
    for (int i = 0; i < FrameDepth; i++) begin
      frame_d[i] = CH_HASH;
    end
    frame_d[0] = CH_LBRACK;
    frame_d[1] = CH_B;
    nb_d       = 3'd3;
    if (first_q == CH_A || first_q == CH_B) begin
      frame_d[1] = (first_q == CH_A) ? CH_X : CH_Y;
      frame_d[2] = CH_S;
      frame_d[3] = (second_q == CH_STAR) ? CH_MINUS : CH_PLUS;
      frame_d[4] = dec_char(dec_tens(dist_cap));
      frame_d[5] = dec_char(dec_ones(dist_cap));
      nb_d       = 3'd7;
    end else if (first_q == CH_C && (second_q inside {[CH_1:CH_8]})) begin
      frame_d[1] = cmd_letter;
      if (cmd_has_slot) begin
        frame_d[2] = slot_c0;
        frame_d[3] = slot_c1;
        frame_d[4] = slot_c2;
        nb_d       = slot_len3 ? 3'd6 : 3'd5;
      end
    end
  end

  // Output byte selection
  assign in_body  = idx_q < {1'b0, nb_q};
  assign tail_pos = idx_q - {1'b0, nb_q};

  always_comb begin
    if (in_body) begin
      cur_byte = frame_q[idx_q[FrameIdxW-1:0]];
    end else begin
      case (tail_pos)
        TAIL_HEX_HI: cur_byte = hex_char(sum_q[7:4]);
        TAIL_HEX_LO: cur_byte = hex_char(sum_q[3:0]);
        TAIL_RBRACK: cur_byte = CH_RBRACK;
        TAIL_CR:     cur_byte = CH_CR;
        default:     cur_byte = CH_LF;
      endcase
    end
  end

  // Running checksum, kept reduced modulo 165
  assign sum_add = {1'b0, sum_q} + {2'b0, cur_byte};

  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    if (cmd_i.load_frame) begin
      idx_d = '0;
      sum_d = '0;
    end else if (cmd_i.advance) begin
      idx_d = idx_q + 4'd1;
      if (in_body) begin
        sum_d = (sum_add >= {1'b0, CSUM_MODULUS}) ? 8'(sum_add - {1'b0, CSUM_MODULUS})
                                                  : sum_add[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
    end
  end

  // Frame buffer payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      frame_q <= frame_d;
      nb_q    <= nb_d;
    end
  end

  assign frame_byte_o    = {1'b0, cur_byte};
  assign sts_o.key_null  = key_char_i == CH_NUL;
  assign sts_o.key_hash  = key_char_i == CH_HASH;
  assign sts_o.last_byte = !in_body && tail_pos == TAIL_LAST;

  `KCF_ASSERT(a_sum_reduced, sum_q < CSUM_MODULUS, "checksum left unreduced")
  `KCF_ASSERT_NEXT(a_load_restarts, cmd_i.load_frame, idx_q == 4'd0 && key_count_q == 2'd0,
                   "frame load did not restart index and clear store")

endmodule

// ----- design/kcf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad command framer controller
// Takes keys while idle, then streams one frame byte per accepted transfer.
// ----------------------------------------------------------------------------
`include "keypad_command_framer_defines.svh"

module kcf_ctrl import kcf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  kcf_sts_t sts_i,
  output kcf_cmd_t cmd_o
);

  kcf_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !sts_i.key_null) begin
          if (sts_i.key_hash) begin
            cmd_o.load_frame = 1'b1;
            state_d          = ST_SEND;
          end else begin
            cmd_o.store_key = 1'b1;
          end
        end
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (sts_i.last_byte) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `KCF_ASSERT(a_one_side, !(in_ready_o && out_valid_o), "input taken while frame is out")
  `KCF_ASSERT_NEXT(a_load_sends, cmd_o.load_frame, out_valid_o, "frame load without output")
  `KCF_ASSERT_NEXT(a_last_frees, cmd_o.advance && sts_i.last_byte, in_ready_o,
                   "input not reopened after line feed")

endmodule

// ----- design/keypad_command_framer.sv -----
`timescale 1ns / 1ps
// Latency: a key other than '#' is stored in the cycle it is taken; after a '#'
// the first frame byte is valid on the next cycle.
// Throughput: one key per cycle while collecting; a '#' then streams 8 to 12 frame
// bytes at one byte per cycle unless stalled; the next key is taken the cycle
// after the line feed leaves. The single-byte output path sets the frame time.
// Reset (asynchronous, active low) clears the key store and sets the limit to 99.
// ----------------------------------------------------------------------------
// Keypad command framer
// Collects keypad keys and emits one checksummed ASCII command frame per '#'.
// ----------------------------------------------------------------------------
module keypad_command_framer import kcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Key input
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [6:0] key_char, [7] zero fill
  // Frame output
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] frame_byte
  output logic       m_axis_tlast,   // frame_end
  // Distance limit write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  kcf_cmd_t cmd;
  kcf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  kcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kcf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_char_i   (s_axis_tdata[KeyW-1:0]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .frame_byte_o (m_axis_tdata)
  );

  assign m_axis_tlast = sts.last_byte;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad command framer testbench
// Streams keypad keys into the framer and checks each returned frame byte
// against a behavioral prediction of the frame. Directed key sequences cover
// the empty, missing, long and saturating entries, then random
// well-formed and broken sequences run with bursty input, a varying output
// stall pattern, one long output hold-off and distance limit rewrites.
// ----------------------------------------------------------------------------
module tb import kcf_pkg::*;;

  localparam int ITEM_TARGET  = 410;     // directed plus random keys
  localparam int CYCLE_LIMIT  = 300000;
  localparam int QUIET_CYCLES = 4;       // settle time before a limit write
  localparam int HOLD_AFTER   = 120;     // frame bytes seen before the long stall
  localparam int HOLD_CYCLES  = 400;
  localparam logic [KeyW-1:0] KEY_MAX = 7'h7F;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // One pending entry: a key, or a distance limit write
  typedef struct packed {
    logic            is_cfg;
    logic [KeyW-1:0] val;
  } pending_t;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            s_valid   = 1'b0;
  logic [7:0]      s_data    = 8'h00;
  logic            m_ready   = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [KeyW-1:0] cfg_data  = '0;
  logic            s_axis_tready;
  logic            m_axis_tvalid;
  logic [7:0]      m_axis_tdata;
  logic            m_axis_tlast;
  logic            cfg_ready_o;

  keypad_command_framer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),          // [6:0] key_char, [7] zero fill
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),    // [7:0] frame_byte
    .m_axis_tlast  (m_axis_tlast),    // frame_end
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  pending_t    pend_q[$];
  frame_byte_t exp_frame_q[$];
  logic [7:0]  frame_acc[$];
  int          key_total    = 0;
  int          error_count  = 0;
  int          quiet_cycles = 0;
  int          bytes_seen   = 0;
  int          cycle_cnt    = 0;

  // Predicted key store and limit
  logic [1:0]      kp_count;
  logic [KeyW-1:0] kp_first, kp_second, kp_third, kp_dist, kp_limit;
  logic            kp_digits_done;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  task automatic clear_store();
    kp_count       = '0;
    kp_first       = CH_NUL;
    kp_second      = CH_NUL;
    kp_third       = CH_NUL;
    kp_dist        = '0;
    kp_digits_done = 1'b0;
  endtask

  // Two decimal digits, or a minus and one or two digits
  task automatic push_dec(input int v);
    int m;
    if (v < 0) begin
      m = -v;
      frame_acc.push_back(8'(CH_MINUS));
      if (m >= 10) frame_acc.push_back(8'(CH_0) + 8'((m / 10) % 10));
      frame_acc.push_back(8'(CH_0) + 8'(m % 10));
    end else begin
      frame_acc.push_back(8'(CH_0) + 8'((v / 10) % 10));
      frame_acc.push_back(8'(CH_0) + 8'(v % 10));
    end
  endtask

  task automatic press_key(input logic [KeyW-1:0] key);
    int          v, slot, sum, nib, i;
    frame_byte_t e;
    if (key == CH_NUL) return;
    // Ordinary key: store it
    if (key != CH_HASH) begin
      case (kp_count)
        2'd0: kp_first = key;
        2'd1: kp_second = key;
        default: begin
          if (kp_count == 2'd2) kp_third = key;
          if (!kp_digits_done && key >= CH_0 && key <= CH_9) begin
            v = int'(kp_dist) * 10 + int'(key) - int'(CH_0);
            kp_dist = (v > int'(DIST_MAX)) ? DIST_MAX : 7'(v);
          end else begin
            kp_digits_done = 1'b1;
          end
        end
      endcase
      if (kp_count != 2'd3) kp_count = kp_count + 2'd1;
      return;
    end
    // Terminator: build the frame
    slot = int'(kp_third) - int'(CH_0);
    frame_acc = {};
    frame_acc.push_back(8'(CH_LBRACK));
    if (kp_first == CH_A || kp_first == CH_B) begin
      v = (kp_dist > kp_limit) ? int'(kp_limit) : int'(kp_dist);
      frame_acc.push_back(8'((kp_first == CH_A) ? CH_X : CH_Y));
      frame_acc.push_back(8'(CH_S));
      frame_acc.push_back(8'((kp_second == CH_STAR) ? CH_MINUS : CH_PLUS));
      push_dec(v);
    end else if (kp_first == CH_C && kp_second >= CH_1 && kp_second <= CH_8) begin
      case (kp_second)
        CH_1: begin
          frame_acc.push_back(8'(CH_S));
          push_dec(slot);
        end
        CH_2: begin
          frame_acc.push_back(8'(CH_G));
          push_dec(slot);
        end
        CH_3: frame_acc.push_back(8'(CH_D));
        CH_4: frame_acc.push_back(8'(CH_U));
        CH_5: frame_acc.push_back(8'(CH_P));
        CH_6: begin
          frame_acc.push_back(8'(CH_E));
          push_dec(slot);
        end
        CH_7: frame_acc.push_back(8'(CH_A));
        default: begin
          frame_acc.push_back(8'(CH_R));
          push_dec(slot);
        end
      endcase
    end else begin
      frame_acc.push_back(8'(CH_B));
    end
    frame_acc.push_back(8'(CH_HASH));
    // Checksum over '[' body '#', as two lowercase hex digits
    sum = 0;
    foreach (frame_acc[i]) sum += int'(frame_acc[i]);
    sum = sum % int'(CSUM_MODULUS);
    for (i = 1; i >= 0; i--) begin
      nib = (sum >> (4 * i)) & 15;
      if (nib < 10) frame_acc.push_back(8'(CH_0) + 8'(nib));
      else frame_acc.push_back(8'(CH_LOW_A) + 8'(nib - 10));
    end
    frame_acc.push_back(8'(CH_RBRACK));
    frame_acc.push_back(8'(CH_CR));
    frame_acc.push_back(8'(CH_LF));
    for (i = 0; i < frame_acc.size(); i++) begin
      e.data = frame_acc[i];
      e.last = (i == frame_acc.size() - 1);
      exp_frame_q.push_back(e);
    end
    clear_store();
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Key and limit driver: bursts of items with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive
    pending_t        nx;
    logic            v_n, c_n, took;
    logic [7:0]      d_n;
    logic [KeyW-1:0] cd_n;
    int              bl, gl;
    if (!rst_ni) begin
      s_valid    <= 1'b0;
      s_data     <= 8'h00;
      cfg_valid  <= 1'b0;
      cfg_data   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      v_n  = s_valid;
      d_n  = s_data;
      c_n  = cfg_valid;
      cd_n = cfg_data;
      bl   = burst_left;
      gl   = gap_left;
      took = s_valid && s_axis_tready;
      if (took) v_n = 1'b0;
      if (cfg_valid && cfg_ready_o) c_n = 1'b0;
      if (!v_n && !c_n) begin
        if (gl > 0) begin
          gl--;
        end else if (pend_q.size() != 0) begin
          if (pend_q[0].is_cfg) begin
            // limit writes only once the framer has gone quiet
            if (!took && !cfg_valid && quiet_cycles >= QUIET_CYCLES) begin
              nx   = pend_q.pop_front();
              c_n  = 1'b1;
              cd_n = nx.val;
            end
          end else begin
            nx  = pend_q.pop_front();
            v_n = 1'b1;
            d_n = {1'b0, nx.val};
            if (bl == 0) bl = $urandom_range(1, 24);
            bl--;
            if (bl == 0) begin
              gl = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
            end
          end
        end
      end
      s_valid    <= v_n;
      s_data     <= d_n;
      cfg_valid  <= c_n;
      cfg_data   <= cd_n;
      burst_left <= bl;
      gap_left   <= gl;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame receiver: stall pattern changes at random intervals, plus one
  // long hold-off so the framer backs up onto its key input
  // ---------------------------------------------------------------------------
  logic [1:0] sink_mode  = 2'd0;
  logic [1:0] sink_phase = 2'd0;
  int         mode_left  = 0;
  int         hold_left  = 0;
  logic       hold_done  = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : sink
    logic r;
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      sink_mode  <= 2'd0;
      sink_phase <= 2'd0;
      mode_left  <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      r = 1'b1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        r = 1'b0;
      end else if (!hold_done && bytes_seen >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        r = 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode <= 2'($urandom_range(0, 3));
          mode_left <= $urandom_range(16, 96);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (sink_mode)
          2'd0: r = 1'b1;
          2'd1: r = 1'($urandom_range(0, 1));
          2'd2: r = (sink_phase == 2'd0);
          default: r = ($urandom_range(0, 3) != 0);
        endcase
      end
      sink_phase <= sink_phase + 2'd1;
      m_ready    <= r;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted keys and limit writes, check frame bytes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check
    frame_byte_t e;
    if (!rst_ni) begin
      kp_limit = LIMIT_RESET;
      clear_store();
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready_o) kp_limit = cfg_data;
      if (s_valid && s_axis_tready) press_key(s_data[KeyW-1:0]);
      if (m_axis_tvalid && m_ready) begin
        bytes_seen <= bytes_seen + 1;
        if (exp_frame_q.size() == 0) begin
          flag_error($sformatf("unexpected frame byte %02h last %0d",
                               m_axis_tdata, m_axis_tlast));
        end else begin
          e = exp_frame_q.pop_front();
          if (m_axis_tdata !== e.data || m_axis_tlast !== e.last) begin
            flag_error($sformatf("frame byte mismatch: expected %02h last %0d, got %02h last %0d",
                                 e.data, e.last, m_axis_tdata, m_axis_tlast));
          end
        end
      end
      quiet_cycles <= (exp_frame_q.size() == 0) ? quiet_cycles + 1 : 0;
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_key(input logic [KeyW-1:0] k);
    pending_t p;
    p.is_cfg = 1'b0;
    p.val    = k;
    pend_q.push_back(p);
    if (k != CH_NUL) key_total++;
  endtask

  task automatic add_cfg(input logic [KeyW-1:0] lim);
    pending_t p;
    p.is_cfg = 1'b1;
    p.val    = lim;
    pend_q.push_back(p);
  endtask

  // Any key code except no-key and the terminator
  function automatic logic [KeyW-1:0] rand_key();
    logic [KeyW-1:0] k;
    k = 7'($urandom_range(1, 126));
    if (k >= CH_HASH) k = k + 7'd1;
    return k;
  endfunction

  function automatic logic [KeyW-1:0] rand_digit();
    return 7'(CH_0 + $urandom_range(0, 9));
  endfunction

  initial begin : main
    int kind, n, i, next_cfg;

    // Directed: empty entry, missing third key, missing second key
    add_key(CH_HASH);
    add_key(CH_C); add_key(CH_1); add_key(CH_HASH);
    add_key(CH_A); add_key(CH_HASH);
    // Out-of-range limit; long entry with no-key and saturating distance
    add_cfg(KEY_MAX);
    add_key(CH_B); add_key(CH_STAR); add_key(CH_1); add_key(CH_NUL);
    add_key(CH_9); add_key(CH_9); add_key(CH_9); add_key(CH_HASH);
    // Zero limit caps every move
    add_cfg('0);
    add_key(CH_A); add_key(CH_PLUS); add_key(CH_5); add_key(CH_HASH);
    // Highest key code as slot
    add_cfg(LIMIT_RESET);
    add_key(CH_C); add_key(CH_2); add_key(KEY_MAX); add_key(CH_HASH);

    // Random sequences, mostly well formed
    next_cfg = key_total + $urandom_range(40, 90);
    while (key_total < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // relative move
        add_key($urandom_range(0, 1) ? CH_A : CH_B);
        if ($urandom_range(0, 1)) add_key(CH_STAR);
        else add_key(($urandom_range(0, 2) == 0) ? rand_key() : rand_digit());
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) add_key(rand_digit());
        if ($urandom_range(0, 3) == 0) begin
          add_key(rand_key());
          add_key(rand_digit());
        end
        if ($urandom_range(0, 5) == 0) add_key(CH_NUL);
        add_key(CH_HASH);
      end else if (kind <= 6) begin
        // slot or actuator command
        add_key(CH_C);
        if ($urandom_range(0, 4) == 0) add_key(rand_key());
        else add_key(7'(CH_1 + $urandom_range(0, 7)));
        if ($urandom_range(0, 4) != 0) begin
          add_key(($urandom_range(0, 2) == 0) ? rand_key() : rand_digit());
        end
        if ($urandom_range(0, 4) == 0) add_key(rand_key());
        add_key(CH_HASH);
      end else if (kind <= 8) begin
        // noise over the whole code range, terminators included
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) add_key(7'($urandom_range(0, 127)));
        add_key(CH_HASH);
      end else begin
        // broken entry that runs into the next one
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) add_key(rand_key());
      end
      if (kind <= 8 && key_total >= next_cfg) begin
        case ($urandom_range(0, 3))
          0: add_cfg('0);
          1: add_cfg(KEY_MAX);
          2: add_cfg(DIST_MAX);
          default: add_cfg(7'($urandom_range(0, 127)));
        endcase
        next_cfg = key_total + $urandom_range(40, 90);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain stimulus, then every expected frame byte
    while (pend_q.size() != 0 || s_valid || cfg_valid) @(negedge clk_i);
    while (exp_frame_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
